@@ rtl/svang_pkg.sv @@
// Shared constants and types for the stick vector angle block.
package svang_pkg;

  // Width of the Q.30 angle accumulator and of every angle in flight
  localparam int ZW = 34;
  localparam int TABLE_LEN = 24;

  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  // floor(atan(2^-i) * 2^30)
  localparam logic [31:0] ATAN_Q30 [0:TABLE_LEN-1] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
    32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
    32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
    32'd262143,    32'd131071,    32'd65535,     32'd32767,
    32'd16383,     32'd8191,      32'd4095,      32'd2047,
    32'd1023,      32'd511,       32'd255,       32'd127
  };

  // Per-item flags carried alongside the rotation stages
  typedef struct packed {
    logic                 special;
    logic                 xpos;
    logic                 ypos;
    logic signed [ZW-1:0] sres;
  } side_t;

endpackage

@@ rtl/svang_sqrt.sv @@
// Pipelined integer square root, one root bit per register stage.
module svang_sqrt #(
  parameter int N  = 24,
  parameter int SW = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [2*N-1:0] in_rad,
  input  logic [SW-1:0]  in_side,
  output logic           out_valid,
  output logic [N-1:0]   out_root,
  output logic [SW-1:0]  out_side
);

  logic           v    [0:N-1];
  logic [2*N-1:0] rad  [0:N-1];
  logic [N+1:0]   rem  [0:N-1];
  logic [N-1:0]   root [0:N-1];
  logic [SW-1:0]  side [0:N-1];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic           p_v;
    logic [2*N-1:0] p_rad;
    logic [N+1:0]   p_rem;
    logic [N-1:0]   p_root;
    logic [SW-1:0]  p_side;
    logic [N+1:0]   remsh;
    logic [N+1:0]   trial;

    if (g == 0) begin : g_first
      assign p_v    = in_valid;
      assign p_rad  = in_rad;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_side = in_side;
    end else begin : g_next
      assign p_v    = v[g-1];
      assign p_rad  = rad[g-1];
      assign p_rem  = rem[g-1];
      assign p_root = root[g-1];
      assign p_side = side[g-1];
    end

    // bring down the next two radicand bits and try the next root bit
    assign remsh = {p_rem[N-1:0], p_rad[2*N-1:2*N-2]};
    assign trial = {p_root, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g] <= 1'b0;
      end else if (en) begin
        v[g] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[g]  <= p_rad << 2;
        side[g] <= p_side;
        if (remsh >= trial) begin
          rem[g]  <= remsh - trial;
          root[g] <= {p_root[N-2:0], 1'b1};
        end else begin
          rem[g]  <= remsh;
          root[g] <= {p_root[N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[N-1];
  assign out_root  = root[N-1];
  assign out_side  = side[N-1];

endmodule

@@ rtl/stick_vector_angle.sv @@
// Top level: joystick sample to direction angle, fully pipelined.
// Each square-root pipeline has a root width of 24 bits for FULL_SCALE = 100.
// Throughput: one sample per cycle; every stage holds while the output register is full and
//   not taken, so the block accepts as long as the output moves.
// Reset: synchronous, active high; clears every stage valid bit, payload is left as is.
module stick_vector_angle #(
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int CORDIC_STEPS    = 16,
  parameter int FULL_SCALE      = 100
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              stick_valid,
  output logic              stick_ready,
  input  logic signed [7:0] stick_x,
  input  logic signed [7:0] stick_y,
  output logic              angle_valid,
  input  logic              angle_ready,
  output logic signed [15:0] angle
);
  import svang_pkg::*;

  // Derived sizes
  localparam int S         = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int TWO_FS2   = 2 * FULL_SCALE * FULL_SCALE;
  localparam int RAD_INT_W = $clog2(TWO_FS2 + 1);
  localparam int N         = (RAD_INT_W + 33) / 2;      // root bits
  localparam int RADW      = 2 * N;                     // radicand bits
  localparam int MW        = (N > 23) ? N : 23;
  localparam int XW        = MW + 1;                    // signed Q.16 coordinate
  localparam int CW        = XW + 2;                    // rotation datapath
  localparam int DW        = ((RAD_INT_W > 15) ? RAD_INT_W : 15) + 1;
  localparam int W2        = ((RADW > 2 * XW) ? RADW : 2 * XW) + 1;
  localparam logic [RADW-1:0] TWO_FS2_Q32 = RADW'(TWO_FS2) << 32;

  // Global advance: every stage moves when the output register is free or being taken
  logic en;
  assign en          = !angle_valid || angle_ready;
  assign stick_ready = en;

  // Input register
  logic              v0;
  logic signed [7:0] sx0, sy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= stick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx0 <= stick_x;
      sy0 <= stick_y;
    end
  end

  // First radicand: (2*FS^2 - y^2) at 32 fractional bits, clamped at zero
  logic signed [15:0]   sy_sq;
  logic signed [DW-1:0] diff1;
  logic [RADW-1:0]      rad1;

  assign sy_sq = sy0 * sy0;
  assign diff1 = DW'(TWO_FS2) - DW'(sy_sq);
  assign rad1  = diff1[DW-1] ? '0 : (RADW'(diff1[DW-2:0]) << 32);

  logic        r1_v;
  logic [N-1:0] root1;
  logic [15:0] side1;

  svang_sqrt #(.N(N), .SW(16)) u_sqrt_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v0),
    .in_rad   (rad1),
    .in_side  ({sx0, sy0}),
    .out_valid(r1_v),
    .out_root (root1),
    .out_side (side1)
  );

  // Remap x where it sits at full scale
  logic signed [7:0]    sx1, sy1;
  logic signed [XW-1:0] mag1, x_next;

  assign sx1  = side1[15:8];
  assign sy1  = side1[7:0];
  assign mag1 = signed'(XW'(root1));

  always_comb begin
    if (int'(sx1) == FULL_SCALE || int'(sx1) == -FULL_SCALE) begin
      x_next = sx1[7] ? -mag1 : mag1;
    end else begin
      x_next = XW'(sx1) <<< 16;
    end
  end

  logic                 v1;
  logic signed [XW-1:0] x1;
  logic signed [7:0]    sy1r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= r1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1   <= x_next;
      sy1r <= sy1;
    end
  end

  // Square the remapped x
  logic                   v2;
  logic signed [2*XW-1:0] xsq2;
  logic signed [XW-1:0]   x2;
  logic signed [7:0]      sy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xsq2 <= x1 * x1;
      x2   <= x1;
      sy2  <= sy1r;
    end
  end

  // Second radicand: 2*FS^2 at Q.32 less x^2, clamped at zero
  logic signed [W2-1:0] diff2;
  logic [RADW-1:0]      rad2;

  assign diff2 = signed'(W2'(TWO_FS2_Q32)) - W2'(xsq2);
  assign rad2  = diff2[W2-1] ? '0 : RADW'(diff2[W2-2:0]);

  logic           r2_v;
  logic [N-1:0]   root2;
  logic [XW+7:0]  side2;

  svang_sqrt #(.N(N), .SW(XW + 8)) u_sqrt_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .in_rad   (rad2),
    .in_side  ({x2, sy2}),
    .out_valid(r2_v),
    .out_root (root2),
    .out_side (side2)
  );

  // Remap y where it sits at full scale, using the updated x
  logic signed [7:0]    sy3;
  logic signed [XW-1:0] x3n, mag2, y_next;

  assign sy3  = side2[7:0];
  assign x3n  = side2[XW+7:8];
  assign mag2 = signed'(XW'(root2));

  always_comb begin
    if (int'(sy3) == FULL_SCALE || int'(sy3) == -FULL_SCALE) begin
      y_next = sy3[7] ? -mag2 : mag2;
    end else begin
      y_next = XW'(sy3) <<< 16;
    end
  end

  logic                 v3;
  logic signed [XW-1:0] x3, y3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= r2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x3 <= x3n;
      y3 <= y_next;
    end
  end

  // Axis and origin cases, and magnitudes for the rotation
  side_t                e_side;
  logic signed [CW-1:0] e_ax, e_ay;

  always_comb begin
    e_side.special = (x3 == '0) || (y3 == '0);
    e_side.xpos    = !x3[XW-1];
    e_side.ypos    = !y3[XW-1] && (y3 != '0);
    if (x3 == '0 && y3 == '0) begin
      e_side.sres = '0;
    end else if (x3 == '0) begin
      e_side.sres = y3[XW-1] ? -HALF_PI_Q30 : HALF_PI_Q30;
    end else if (x3[XW-1]) begin
      e_side.sres = -PI_Q30;
    end else begin
      e_side.sres = '0;
    end
    e_ax = x3[XW-1] ? -CW'(x3) : CW'(x3);
    e_ay = y3[XW-1] ? -CW'(y3) : CW'(y3);
  end

  // Vectoring rotations, one micro-rotation per stage
  logic                 c_v [0:S];
  logic signed [CW-1:0] c_x [0:S];
  logic signed [CW-1:0] c_y [0:S];
  logic signed [ZW-1:0] c_z [0:S];
  side_t                c_s [0:S];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v[0] <= 1'b0;
    end else if (en) begin
      c_v[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_x[0] <= e_ax;
      c_y[0] <= e_ay;
      c_z[0] <= '0;
      c_s[0] <= e_side;
    end
  end

  for (genvar i = 0; i < S; i++) begin : g_rot
    logic signed [CW-1:0] dx, dy;

    assign dx = c_y[i] >>> i;
    assign dy = c_x[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        c_v[i+1] <= 1'b0;
      end else if (en) begin
        c_v[i+1] <= c_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_s[i+1] <= c_s[i];
        if (!c_y[i][CW-1]) begin
          c_x[i+1] <= c_x[i] + dx;
          c_y[i+1] <= c_y[i] - dy;
          c_z[i+1] <= c_z[i] + ZW'(ATAN_Q30[i]);
        end else begin
          c_x[i+1] <= c_x[i] - dx;
          c_y[i+1] <= c_y[i] + dy;
          c_z[i+1] <= c_z[i] - ZW'(ATAN_Q30[i]);
        end
      end
    end
  end

  // Clamp the first-quadrant angle and fold it into its quadrant, or take the axis/origin result
  logic signed [ZW-1:0] zc, res_next;
  side_t                fs;

  assign fs = c_s[S];

  always_comb begin
    if (c_z[S][ZW-1]) begin
      zc = '0;
    end else if (c_z[S] > HALF_PI_Q30) begin
      zc = HALF_PI_Q30;
    end else begin
      zc = c_z[S];
    end
    if (fs.special) begin
      res_next = fs.sres;
    end else if (fs.xpos) begin
      res_next = fs.ypos ? zc : -zc;
    end else begin
      res_next = fs.ypos ? (PI_Q30 - zc) : (zc - PI_Q30);
    end
  end

  logic                 q_v;
  logic signed [ZW-1:0] res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_v <= 1'b0;
    end else if (en) begin
      q_v <= c_v[S];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_q <= res_next;
    end
  end

  // Round half up to the output precision and saturate to 16 bits
  logic signed [ZW-1:0] rnd, shf;
  logic signed [15:0]   angle_next;

  assign rnd = res_q + (ZW'(1) <<< (29 - ANGLE_FRAC_BITS));
  assign shf = rnd >>> (30 - ANGLE_FRAC_BITS);

  always_comb begin
    if (shf > ZW'(32767)) begin
      angle_next = 16'sh7FFF;
    end else if (shf < -ZW'(32768)) begin
      angle_next = 16'sh8000;
    end else begin
      angle_next = shf[15:0];
    end
  end

  // Output register: hold until the result transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_valid <= 1'b0;
    end else if (en) begin
      angle_valid <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= angle_next;
    end
  end

  // Checks
  a_enter: assert property (@(posedge clk) disable iff (rst)
    stick_valid && stick_ready |=> v0)
    else $error("accepted sample did not enter the pipeline");

  a_reset: assert property (@(posedge clk)
    rst |=> !angle_valid && !v0 && !q_v)
    else $error("valid bits not cleared by reset");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    q_v && en |=> angle_valid)
    else $error("final stage result lost on its way to the output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(res_q) && $stable(q_v))
    else $error("pipeline moved while the output was stalled");

endmodule
